/* src/whp_pkg.sv */
// Shared types and constants for the WAV header parser and PCM extractor.
`timescale 1ns / 1ps
package whp_pkg;

   typedef enum logic [1:0] {
      ST_STREAM,
      ST_MUL,
      ST_DIV,
      ST_HDR
   } ctrl_state_type;

   typedef enum logic [2:0] {
      HDR_OK        = 3'd0,
      HDR_NO_RIFF   = 3'd1,
      HDR_NO_WAVE   = 3'd2,
      HDR_NO_FMT    = 3'd3,
      HDR_NOT_PCM   = 3'd4,
      HDR_NO_DATA   = 3'd5,
      HDR_RATE_HIGH = 3'd6,
      HDR_ZERO_DIV  = 3'd7
   } hdr_status_type;

   localparam logic [5:0]  HDR_LEN          = 6'd44;
   localparam logic [5:0]  HDR_LAST         = 6'd43;
   localparam logic [7:0]  PCM_FORMAT       = 8'h01;
   localparam logic [31:0] RATE_LIMIT_RESET = 32'd48000;
   localparam logic [4:0]  DIV_STEP_LAST    = 5'd31;
   localparam logic        KIND_HEADER      = 1'b0;
   localparam logic        KIND_SAMPLE      = 1'b1;

   typedef struct packed {
      logic byte_step;
      logic div_load;
      logic div_step;
      logic hdr_emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic hdr_last;
      logic out_full;
   } dp_status_type;

   // expected tag characters of the canonical header
   function automatic logic [7:0] tag_char(input logic [5:0] pos);
      logic [7:0] c;
      case (pos)
         6'd0:    c = 8'h52;
         6'd1:    c = 8'h49;
         6'd2:    c = 8'h46;
         6'd3:    c = 8'h46;
         6'd8:    c = 8'h57;
         6'd9:    c = 8'h41;
         6'd10:   c = 8'h56;
         6'd11:   c = 8'h45;
         6'd12:   c = 8'h66;
         6'd13:   c = 8'h6d;
         6'd14:   c = 8'h74;
         6'd15:   c = 8'h20;
         6'd36:   c = 8'h64;
         6'd37:   c = 8'h61;
         6'd38:   c = 8'h74;
         6'd39:   c = 8'h61;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

/* src/whp_ctrl.sv */
// Controller: byte acceptance, divide sequencing and header result issue.
`timescale 1ns / 1ps
module whp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   rsp_stall,
   input  whp_pkg::dp_status_type status,
   output whp_pkg::ctrl_cmd_type  cmd
);

   whp_pkg::ctrl_state_type state_ff, state_in;
   logic [4:0] div_cnt_ff, div_cnt_in;
   logic       accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= whp_pkg::ST_STREAM;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_comb begin
      req_stall  = (state_ff != whp_pkg::ST_STREAM) | (status.out_full & rsp_stall);
      accept     = req_valid & ~req_stall;
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      case (state_ff)
         whp_pkg::ST_STREAM: begin
            cmd.byte_step = accept;
            if (accept && status.hdr_last) begin
               state_in = whp_pkg::ST_MUL;
            end
         end
         whp_pkg::ST_MUL: begin
            cmd.div_load = 1'b1;
            div_cnt_in   = '0;
            state_in     = whp_pkg::ST_DIV;
         end
         whp_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 5'd1;
            if (div_cnt_ff == whp_pkg::DIV_STEP_LAST) begin
               state_in = whp_pkg::ST_HDR;
            end
         end
         whp_pkg::ST_HDR: begin
            if (!status.out_full || !rsp_stall) begin
               cmd.hdr_emit = 1'b1;
               state_in     = whp_pkg::ST_STREAM;
            end
         end
         default: begin
            state_in = whp_pkg::ST_STREAM;
         end
      endcase
   end

endmodule

/* src/whp_datapath.sv */
// Datapath: header fields, frame divider, sample extraction and output register.
`timescale 1ns / 1ps
module whp_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  whp_pkg::ctrl_cmd_type  cmd,
   output whp_pkg::dp_status_type status,
   input  logic [7:0]             req_in_byte,
   input  logic                   req_file_start,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_item_kind,
   output logic [2:0]             rsp_header_status,
   output logic [15:0]            rsp_channel_count,
   output logic [15:0]            rsp_sample_bits,
   output logic [31:0]            rsp_rate_hz,
   output logic [31:0]            rsp_frame_total,
   output logic signed [15:0]     rsp_pcm_sample,
   output logic                   rsp_final_sample,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [31:0]            csr_rate_limit
);

   logic [31:0] rate_limit_ff, rate_limit_in;
   logic [5:0]  pos_ff, pos_in;
   logic [1:0]  phase_ff, phase_in;
   whp_pkg::hdr_status_type err_ff, err_in;
   logic [15:0] chan_ff, chan_in;
   logic [15:0] bits_ff, bits_in;
   logic [31:0] rate_ff, rate_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] left_ff, left_in;
   logic [7:0]  low_ff, low_in;
   logic        done_ff, done_in;

   logic [28:0] divisor_ff, divisor_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff, out_kind_in;
   logic [2:0]  out_status_ff, out_status_in;
   logic [15:0] out_chan_ff, out_chan_in;
   logic [15:0] out_bits_ff, out_bits_in;
   logic [31:0] out_rate_ff, out_rate_in;
   logic [31:0] out_frames_ff, out_frames_in;
   logic [15:0] out_sample_ff, out_sample_in;
   logic        out_final_ff, out_final_in;

   logic [7:0]  b;
   logic [32:0] rem_sh;
   logic [32:0] rem_diff;
   logic        eight;
   logic [1:0]  phase_last;
   logic        final_beat;
   whp_pkg::hdr_status_type hstat;
   logic [31:0] frames;

   assign b         = req_in_byte;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_limit_ff <= whp_pkg::RATE_LIMIT_RESET;
         pos_ff        <= '0;
         phase_ff      <= '0;
         err_ff        <= whp_pkg::HDR_OK;
         chan_ff       <= '0;
         bits_ff       <= '0;
         rate_ff       <= '0;
         size_ff       <= '0;
         left_ff       <= '0;
         low_ff        <= '0;
         done_ff       <= 1'b1;
         out_valid_ff  <= 1'b0;
      end else begin
         rate_limit_ff <= rate_limit_in;
         pos_ff        <= pos_in;
         phase_ff      <= phase_in;
         err_ff        <= err_in;
         chan_ff       <= chan_in;
         bits_ff       <= bits_in;
         rate_ff       <= rate_in;
         size_ff       <= size_in;
         left_ff       <= left_in;
         low_ff        <= low_in;
         done_ff       <= done_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff    <= divisor_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      out_kind_ff   <= out_kind_in;
      out_status_ff <= out_status_in;
      out_chan_ff   <= out_chan_in;
      out_bits_ff   <= out_bits_in;
      out_rate_ff   <= out_rate_in;
      out_frames_ff <= out_frames_in;
      out_sample_ff <= out_sample_in;
      out_final_ff  <= out_final_in;
   end

   always_comb begin
      status.hdr_last = ~req_file_start & ~done_ff & (pos_ff == whp_pkg::HDR_LAST);
      status.out_full = out_valid_ff;
   end

   // frame stride decode
   always_comb begin
      eight = (bits_ff == 16'd8);
      if (eight) begin
         phase_last = (chan_ff == 16'd2) ? 2'd1 : 2'd0;
      end else begin
         phase_last = (chan_ff == 16'd2) ? 2'd3 : 2'd1;
      end
      final_beat = (left_ff == 32'd1);
   end

   // header verdict, frame count and divider trial subtraction
   always_comb begin
      if (err_ff != whp_pkg::HDR_OK) begin
         hstat = err_ff;
      end else if (rate_ff > rate_limit_ff) begin
         hstat = whp_pkg::HDR_RATE_HIGH;
      end else if (divisor_ff == '0) begin
         hstat = whp_pkg::HDR_ZERO_DIV;
      end else begin
         hstat = whp_pkg::HDR_OK;
      end
      frames   = (divisor_ff == '0) ? 32'd0 : quo_ff;
      rem_sh   = {rem_ff, quo_ff[31]};
      rem_diff = rem_sh - {4'b0000, divisor_ff};
   end

   always_comb begin
      rate_limit_in = rate_limit_ff;
      pos_in        = pos_ff;
      phase_in      = phase_ff;
      err_in        = err_ff;
      chan_in       = chan_ff;
      bits_in       = bits_ff;
      rate_in       = rate_ff;
      size_in       = size_ff;
      left_in       = left_ff;
      low_in        = low_ff;
      done_in       = done_ff;
      divisor_in    = divisor_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      out_valid_in  = out_valid_ff & rsp_stall;
      out_kind_in   = out_kind_ff;
      out_status_in = out_status_ff;
      out_chan_in   = out_chan_ff;
      out_bits_in   = out_bits_ff;
      out_rate_in   = out_rate_ff;
      out_frames_in = out_frames_ff;
      out_sample_in = out_sample_ff;
      out_final_in  = out_final_ff;

      if (csr_valid && csr_ready) begin
         rate_limit_in = csr_rate_limit;
      end

      if (cmd.byte_step) begin
         if (req_file_start) begin
            pos_in   = '0;
            phase_in = '0;
            err_in   = whp_pkg::HDR_OK;
            chan_in  = '0;
            bits_in  = '0;
            rate_in  = '0;
            size_in  = '0;
            left_in  = '0;
            low_in   = '0;
            done_in  = 1'b0;
         end
         if (!done_in) begin
            if (pos_in < whp_pkg::HDR_LEN) begin
               case (pos_in) inside
                  [6'd0:6'd3]: begin
                     if (b != whp_pkg::tag_char(pos_in) && err_in == whp_pkg::HDR_OK) begin
                        err_in = whp_pkg::HDR_NO_RIFF;
                     end
                  end
                  [6'd8:6'd11]: begin
                     if (b != whp_pkg::tag_char(pos_in) && err_in == whp_pkg::HDR_OK) begin
                        err_in = whp_pkg::HDR_NO_WAVE;
                     end
                  end
                  [6'd12:6'd15]: begin
                     if (b != whp_pkg::tag_char(pos_in) && err_in == whp_pkg::HDR_OK) begin
                        err_in = whp_pkg::HDR_NO_FMT;
                     end
                  end
                  6'd20: begin
                     if (b != whp_pkg::PCM_FORMAT && err_in == whp_pkg::HDR_OK) begin
                        err_in = whp_pkg::HDR_NOT_PCM;
                     end
                  end
                  6'd21: begin
                     if (b != 8'h00 && err_in == whp_pkg::HDR_OK) begin
                        err_in = whp_pkg::HDR_NOT_PCM;
                     end
                  end
                  [6'd22:6'd23]: begin
                     chan_in[{pos_in[0], 3'b000} +: 8] = b;
                  end
                  [6'd24:6'd27]: begin
                     rate_in[{pos_in[1:0], 3'b000} +: 8] = b;
                  end
                  [6'd34:6'd35]: begin
                     bits_in[{pos_in[0], 3'b000} +: 8] = b;
                  end
                  [6'd36:6'd39]: begin
                     if (b != whp_pkg::tag_char(pos_in) && err_in == whp_pkg::HDR_OK) begin
                        err_in = whp_pkg::HDR_NO_DATA;
                     end
                  end
                  [6'd40:6'd43]: begin
                     size_in[{pos_in[1:0], 3'b000} +: 8] = b;
                  end
                  default: begin
                  end
               endcase
               pos_in = pos_in + 6'd1;
            end else begin
               phase_in = (phase_ff >= phase_last) ? 2'd0 : phase_ff + 2'd1;
               if (!eight && phase_ff == 2'd0) begin
                  low_in = b;
               end
               if ((eight && phase_ff == 2'd0) || (!eight && phase_ff == 2'd1)) begin
                  out_valid_in  = 1'b1;
                  out_kind_in   = whp_pkg::KIND_SAMPLE;
                  out_status_in = whp_pkg::HDR_OK;
                  out_chan_in   = '0;
                  out_bits_in   = '0;
                  out_rate_in   = '0;
                  out_frames_in = '0;
                  out_sample_in = eight ? {b ^ 8'h80, 8'h00} : {b, low_ff};
                  out_final_in  = final_beat;
                  left_in       = left_ff - 32'd1;
                  if (final_beat) begin
                     done_in = 1'b1;
                  end
               end
            end
         end
      end

      if (cmd.div_load) begin
         divisor_in = 29'(chan_ff) * 29'(bits_ff[15:3]);
         rem_in     = '0;
         quo_in     = size_ff;
      end

      if (cmd.div_step) begin
         if (!rem_diff[32]) begin
            rem_in = rem_diff[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_sh[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
      end

      if (cmd.hdr_emit) begin
         out_valid_in  = 1'b1;
         out_kind_in   = whp_pkg::KIND_HEADER;
         out_status_in = hstat;
         out_chan_in   = chan_ff;
         out_bits_in   = bits_ff;
         out_rate_in   = rate_ff;
         out_frames_in = frames;
         out_sample_in = '0;
         out_final_in  = 1'b0;
         left_in       = frames;
         if (hstat != whp_pkg::HDR_OK || frames == '0) begin
            done_in = 1'b1;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_item_kind     = out_kind_ff;
   assign rsp_header_status = out_status_ff;
   assign rsp_channel_count = out_chan_ff;
   assign rsp_sample_bits   = out_bits_ff;
   assign rsp_rate_hz       = out_rate_ff;
   assign rsp_frame_total   = out_frames_ff;
   assign rsp_pcm_sample    = $signed(out_sample_ff);
   assign rsp_final_sample  = out_final_ff;

endmodule

/* src/wav_header_parser_pcm_extractor.sv */
// A sample beat is registered; it appears in the cycle after its last byte is taken.
// After header byte 43, the header result goes through the divisor multiply state,
// the radix-2 frame-count divider and the issue state, which waits on a stall.
// Throughput: one byte per cycle; header work or a stalled output raises req_stall.
// Reset: idle, rate limit 48000, bytes ignored until a beat with req_file_start.
`timescale 1ns / 1ps
module wav_header_parser_pcm_extractor (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_in_byte,
   input  logic               req_file_start,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_item_kind,
   output logic [2:0]         rsp_header_status,
   output logic [15:0]        rsp_channel_count,
   output logic [15:0]        rsp_sample_bits,
   output logic [31:0]        rsp_rate_hz,
   output logic [31:0]        rsp_frame_total,
   output logic signed [15:0] rsp_pcm_sample,
   output logic               rsp_final_sample,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [31:0]        csr_rate_limit
);

   whp_pkg::ctrl_cmd_type  cmd;
   whp_pkg::dp_status_type status;

   whp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   whp_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_in_byte       (req_in_byte),
      .req_file_start    (req_file_start),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_item_kind     (rsp_item_kind),
      .rsp_header_status (rsp_header_status),
      .rsp_channel_count (rsp_channel_count),
      .rsp_sample_bits   (rsp_sample_bits),
      .rsp_rate_hz       (rsp_rate_hz),
      .rsp_frame_total   (rsp_frame_total),
      .rsp_pcm_sample    (rsp_pcm_sample),
      .rsp_final_sample  (rsp_final_sample),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_rate_limit    (csr_rate_limit)
   );

endmodule
